// File: rtl/core/lcdnw_pkg.sv
`timescale 1ns / 1ps

package lcdnw_pkg;

  // Width of the number that is printed; the field on the port stays 32 bits.
  localparam int unsigned NUMBER_WIDTH = 32;
  localparam int unsigned NumFieldW    = 32;

  // Digits of a 32-bit value, and the bits for a digit count (0..MaxDigits).
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  localparam logic [NumFieldW-1:0] NumMask =
      (NUMBER_WIDTH >= NumFieldW) ? {NumFieldW{1'b1}}
                                  : ((NumFieldW'(1) << NUMBER_WIDTH) - NumFieldW'(1));

  // Divide by ten: q = (x * ceil(2^35 / 10)) >> 35, exact for any 32-bit x.
  localparam logic [31:0]  Recip10    = 32'hCCCC_CCCD;
  localparam int unsigned  Recip10Shr = 35;
  localparam int unsigned  QuotW      = 64 - Recip10Shr;

  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] PosLine1  = 8'd128;
  localparam logic [7:0] PosLine2  = 8'd192;

  localparam logic [1:0] LINE_1 = 2'd1;
  localparam logic [1:0] LINE_2 = 2'd2;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_CHAR = 2'd1,
    REQ_NUM  = 2'd2,
    REQ_POS  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic load;      // capture the request
    logic div_step;  // peel one decimal digit
    logic pop;       // drop the digit just sent
    logic sel_hi;    // drive the high nibble
  } dp_cmd_t;

  typedef struct packed {
    logic last_digit;  // current divide step yields the final digit
    logic last_byte;   // the byte on the bus is the final one of the request
  } dp_status_t;

endpackage

// File: rtl/core/lcdnw_if.sv
`timescale 1ns / 1ps

interface lcdnw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  byte_value;
  logic [31:0] number;
  logic [1:0]  line;
  logic [5:0]  column;

  modport source (output valid, req_type, byte_value, number, line, column, input ready);
  modport sink   (input valid, req_type, byte_value, number, line, column, output ready);
endinterface

interface lcdnw_nib_if;
  logic       valid;
  logic       ready;
  logic [3:0] nibble;
  logic       reg_select;
  logic       last;

  modport source (output valid, nibble, reg_select, last, input ready);
  modport sink   (input valid, nibble, reg_select, last, output ready);
endinterface

// File: rtl/core/lcdnw_dp.sv
`timescale 1ns / 1ps

module lcdnw_dp
  import lcdnw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           byte_value_i,
  input  logic [NumFieldW-1:0] number_i,
  input  logic [1:0]           line_i,
  input  logic [5:0]           column_i,
  output dp_status_t           status_o,
  output logic [3:0]           nibble_o,
  output logic                 reg_select_o
);

  logic                 num_mode_q;
  logic [CntW-1:0]      cnt_q;
  logic [NumFieldW-1:0] num_q;
  logic [7:0]           byte_q;
  logic                 rs_q;
  logic [3:0]           digit_q [MaxDigits];

  logic [63:0]          prod;
  logic [QuotW-1:0]     quot;
  logic [NumFieldW-1:0] rem_full;
  logic [IdxW-1:0]      top_idx;
  logic [7:0]           cur_byte;
  logic [7:0]           load_byte;
  logic                 load_rs;

  assign prod     = 64'(num_q) * 64'(Recip10);
  assign quot     = prod[63:Recip10Shr];
  assign rem_full = num_q - NumFieldW'({quot, 3'b000})
                          - NumFieldW'({quot, 1'b0});

  assign top_idx  = (cnt_q == '0) ? '0 : IdxW'(cnt_q - CntW'(1));
  assign cur_byte = num_mode_q ? (AsciiZero + {4'h0, digit_q[top_idx]}) : byte_q;

  assign nibble_o     = cmd_i.sel_hi ? cur_byte[7:4] : cur_byte[3:0];
  assign reg_select_o = rs_q;

  assign status_o.last_digit = (quot == '0) || (cnt_q == CntW'(MaxDigits - 1));
  assign status_o.last_byte  = !num_mode_q || (cnt_q == CntW'(1));

  always_comb begin
    load_byte = byte_value_i;
    load_rs   = RS_INSTR;
    unique case (req_type_e'(req_type_i))
      REQ_CMD: begin
        load_byte = byte_value_i;
        load_rs   = RS_INSTR;
      end
      REQ_CHAR: begin
        load_byte = byte_value_i;
        load_rs   = RS_DATA;
      end
      REQ_NUM: begin
        load_byte = byte_value_i;
        load_rs   = RS_DATA;
      end
      REQ_POS: begin
        load_byte = ((line_i == LINE_2) ? PosLine2 : PosLine1) + {2'b00, column_i};
        load_rs   = RS_INSTR;
      end
      default: begin
        load_byte = byte_value_i;
        load_rs   = RS_INSTR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_mode_q <= 1'b0;
      cnt_q      <= '0;
    end else if (cmd_i.load) begin
      num_mode_q <= (req_type_e'(req_type_i) == REQ_NUM);
      cnt_q      <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.pop) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q  <= number_i & NumMask;
      byte_q <= load_byte;
      rs_q   <= load_rs;
    end else if (cmd_i.div_step) begin
      num_q                     <= NumFieldW'(quot);
      digit_q[IdxW'(cnt_q)]     <= rem_full[3:0];
    end
  end

endmodule

// File: rtl/core/lcdnw_ctrl.sv
`timescale 1ns / 1ps

module lcdnw_ctrl
  import lcdnw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [1:0] line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_last_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HI,
    ST_LO
  } state_e;

  state_e state_q, state_d;
  logic   line_ok;

  assign line_ok = (line_i == LINE_1) || (line_i == LINE_2);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    out_last_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (req_type_e'(req_type_i) == REQ_NUM) begin
            state_d = ST_DIV;
          end else if (req_type_e'(req_type_i) == REQ_POS && !line_ok) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_HI;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_digit) begin
          state_d = ST_HI;
        end
      end
      ST_HI: begin
        out_valid_o  = 1'b1;
        cmd_o.sel_hi = 1'b1;
        if (out_ready_i) begin
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        out_valid_o = 1'b1;
        out_last_o  = status_i.last_byte;
        if (out_ready_i) begin
          if (status_i.last_byte) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = ST_HI;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a transaction is pending");

  a_num_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_e'(req_type_i) == REQ_NUM) |=> cmd_o.div_step)
    else $error("number request did not start digit extraction");

  a_last_on_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_last_o |-> (out_valid_o && !cmd_o.sel_hi))
    else $error("last flagged outside the low nibble");

  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("block not idle after final transaction");

endmodule

// File: rtl/core/lcd_4bit_nibble_writer_core.sv
// Order: command, character and cursor requests show their first nibble the cycle after
//   acceptance, but a cursor request whose line is neither 1 nor 2 is dropped without output;
//   a number request first divides once per decimal digit (1..10). Throughput: one request at
//   a time; 2 transfers per byte at one per cycle when the sink is ready.
// Reset: asynchronous active low; returns the controller to idle and clears the digit count.
`timescale 1ns / 1ps

module lcd_4bit_nibble_writer_core
  import lcdnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdnw_req_if.sink   req,
  lcdnw_nib_if.source nib
);

  // Controller and datapath talk only through these two groups.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: idle -> (divide per digit) -> high nibble -> low nibble, per byte.
  // Ready is asserted only in idle, so a request is never taken while a
  // transaction is still pending on the nibble side.
  lcdnw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .req_type_i  (req.req_type),
    .line_i      (req.line),
    .out_valid_o (nib.valid),
    .out_ready_i (nib.ready),
    .out_last_o  (nib.last),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: byte register, reciprocal divide-by-ten, and a digit stack that
  // is filled least significant first and drained most significant first.
  lcdnw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req.req_type),
    .byte_value_i (req.byte_value),
    .number_i     (req.number),
    .line_i       (req.line),
    .column_i     (req.column),
    .status_o     (status),
    .nibble_o     (nib.nibble),
    .reg_select_o (nib.reg_select)
  );

endmodule
